[hw/rtl/hkc_pkg.sv]
// Shared types, key usage constants and QWERTY lookup tables for the key-to-code-point block.
package hkc_pkg;

	// Event type codes
	localparam logic [1:0] EVT_SYNC    = 2'd0;
	localparam logic [1:0] EVT_PRESS   = 2'd1;
	localparam logic [1:0] EVT_RELEASE = 2'd2;
	localparam logic [1:0] EVT_CANCEL  = 2'd3;

	// HID usages of the modifier keys (page 7)
	localparam logic [31:0] KEY_CAPS_LOCK   = 32'h0007_0039;
	localparam logic [31:0] KEY_LEFT_CTRL   = 32'h0007_00E0;
	localparam logic [31:0] KEY_LEFT_SHIFT  = 32'h0007_00E1;
	localparam logic [31:0] KEY_LEFT_ALT    = 32'h0007_00E2;
	localparam logic [31:0] KEY_RIGHT_CTRL  = 32'h0007_00E4;
	localparam logic [31:0] KEY_RIGHT_SHIFT = 32'h0007_00E5;
	localparam logic [31:0] KEY_RIGHT_ALT   = 32'h0007_00E6;

	localparam logic [15:0] KBD_PAGE = 16'h0007;
	localparam logic [15:0] ROM_SIZE = 16'd100;

	// Held modifier bit positions
	localparam int MOD_LSHIFT = 0;
	localparam int MOD_RSHIFT = 1;
	localparam int MOD_LCTRL  = 2;
	localparam int MOD_RCTRL  = 3;
	localparam int MOD_LALT   = 4;
	localparam int MOD_RALT   = 5;

	typedef struct packed {
		logic        kind_valid;
		logic [1:0]  kind;
		logic        has_key;
		logic [31:0] key_usage;
		logic        has_meaning;
		logic        meaning_is_codepoint;
		logic [20:0] meaning_codepoint;
	} evt_item_t;

	typedef struct packed {
		logic        accepted;
		logic [20:0] code_point;
		logic [6:0]  modifier_mask;
		logic        shift_active;
		logic [31:0] last_key_usage;
	} res_item_t;

	// Tracker state after the update, plus the verdict on the transaction
	typedef struct packed {
		logic        accepted;
		logic        caps;
		logic [5:0]  mods;
		logic [31:0] key;
		logic        cp_valid;
		logic [20:0] cp;
	} hkc_view_t;

	// Held-modifier bit for a usage, zero for any other key
	function automatic logic [5:0] mod_bit(input logic [31:0] usage);
		logic [5:0] b;
		b = '0;
		unique case (usage)
			KEY_LEFT_SHIFT:  b[MOD_LSHIFT] = 1'b1;
			KEY_RIGHT_SHIFT: b[MOD_RSHIFT] = 1'b1;
			KEY_LEFT_CTRL:   b[MOD_LCTRL]  = 1'b1;
			KEY_RIGHT_CTRL:  b[MOD_RCTRL]  = 1'b1;
			KEY_LEFT_ALT:    b[MOD_LALT]   = 1'b1;
			KEY_RIGHT_ALT:   b[MOD_RALT]   = 1'b1;
			default:         b = '0;
		endcase
		return b;
	endfunction

	// Unshifted column of the QWERTY table
	function automatic logic [7:0] rom_plain(input logic [6:0] id);
		logic [7:0] c;
		c = 8'h00;
		unique case (id) inside
			[7'd4:7'd29]:  c = 8'(8'h61 + {1'b0, id} - 8'd4);
			[7'd30:7'd38]: c = 8'(8'h31 + {1'b0, id} - 8'd30);
			7'd39:         c = 8'h30;
			7'd44:         c = 8'h20;
			7'd45:         c = 8'h2D;
			7'd46:         c = 8'h3D;
			7'd47:         c = 8'h5B;
			7'd48:         c = 8'h5D;
			7'd49:         c = 8'h5C;
			7'd51:         c = 8'h3B;
			7'd52:         c = 8'h27;
			7'd53:         c = 8'h60;
			7'd54:         c = 8'h2C;
			7'd55:         c = 8'h2E;
			7'd56:         c = 8'h2F;
			7'd84:         c = 8'h2F;
			7'd85:         c = 8'h2A;
			7'd86:         c = 8'h2D;
			7'd87:         c = 8'h2B;
			[7'd89:7'd97]: c = 8'(8'h31 + {1'b0, id} - 8'd89);
			7'd98:         c = 8'h30;
			7'd99:         c = 8'h2E;
			default:       c = 8'h00;
		endcase
		return c;
	endfunction

	// Shifted column; keypad keys hold zero here
	function automatic logic [7:0] rom_shift(input logic [6:0] id);
		logic [7:0] c;
		c = 8'h00;
		unique case (id) inside
			[7'd4:7'd29]: c = 8'(8'h41 + {1'b0, id} - 8'd4);
			7'd30:        c = 8'h21;
			7'd31:        c = 8'h40;
			7'd32:        c = 8'h23;
			7'd33:        c = 8'h24;
			7'd34:        c = 8'h25;
			7'd35:        c = 8'h5E;
			7'd36:        c = 8'h26;
			7'd37:        c = 8'h2A;
			7'd38:        c = 8'h28;
			7'd39:        c = 8'h29;
			7'd44:        c = 8'h20;
			7'd45:        c = 8'h5F;
			7'd46:        c = 8'h2B;
			7'd47:        c = 8'h7B;
			7'd48:        c = 8'h7D;
			7'd49:        c = 8'h7C;
			7'd51:        c = 8'h3A;
			7'd52:        c = 8'h22;
			7'd53:        c = 8'h7E;
			7'd54:        c = 8'h3C;
			7'd55:        c = 8'h3E;
			7'd56:        c = 8'h3F;
			default:      c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

[hw/rtl/hkc_tracker.sv]
// Modifier, caps lock and last-event state, updated once per advancing transaction.
module hkc_tracker
	import hkc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      advance,
	input  evt_item_t evt,
	output hkc_view_t view
);

	logic        caps_q;
	logic [5:0]  mods_q;
	logic [31:0] key_q;
	logic        cp_valid_q;
	logic [20:0] cp_q;

	logic        acc;
	logic        caps_d;
	logic [5:0]  mods_d;
	logic [5:0]  bit_sel;
	logic        is_caps;

	// Work out the state that this transaction leaves behind
	always_comb begin
		acc     = evt.kind_valid && (evt.has_key || evt.has_meaning);
		bit_sel = mod_bit(evt.key_usage);
		is_caps = (evt.key_usage == KEY_CAPS_LOCK);
		caps_d  = caps_q;
		mods_d  = mods_q;
		if (acc && evt.has_key) begin
			unique case (evt.kind)
				EVT_SYNC: begin
					mods_d = mods_q | bit_sel;
					if (is_caps) caps_d = 1'b1;
				end
				EVT_PRESS: begin
					mods_d = mods_q | bit_sel;
					if (is_caps) caps_d = ~caps_q;
				end
				EVT_RELEASE: mods_d = mods_q & ~bit_sel;
				EVT_CANCEL:  mods_d = mods_q;
				default:     mods_d = mods_q;
			endcase
		end

		view.accepted = acc;
		view.caps     = caps_d;
		view.mods     = mods_d;
		if (acc) begin
			view.key      = evt.has_key ? evt.key_usage : '0;
			view.cp_valid = evt.has_meaning && evt.meaning_is_codepoint;
			view.cp       = (evt.has_meaning && evt.meaning_is_codepoint)
				? evt.meaning_codepoint : '0;
		end else begin
			view.key      = key_q;
			view.cp_valid = cp_valid_q;
			view.cp       = cp_q;
		end
	end

	// Commit the new state when the transaction moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			caps_q     <= 1'b0;
			mods_q     <= '0;
			key_q      <= '0;
			cp_valid_q <= 1'b0;
			cp_q       <= '0;
		end else if (advance) begin
			caps_q     <= view.caps;
			mods_q     <= view.mods;
			key_q      <= view.key;
			cp_valid_q <= view.cp_valid;
			cp_q       <= view.cp;
		end
	end

	// A rejected transaction leaves every flag and the stored event alone
	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !acc |=> $stable(mods_q) && $stable(caps_q) && $stable(key_q)
			&& $stable(cp_q))
		else $error("rejected event changed state");

	// A meaning without a key must not touch the modifiers
	a_meaning_only: assert property (@(posedge clk) disable iff (!arst_n)
		advance && acc && !evt.has_key |=> $stable(mods_q) && $stable(caps_q))
		else $error("keyless event changed modifiers");

	// Releasing left shift clears its flag
	a_lshift_release: assert property (@(posedge clk) disable iff (!arst_n)
		advance && acc && evt.has_key && evt.kind == EVT_RELEASE
			&& evt.key_usage == KEY_LEFT_SHIFT |=> !mods_q[MOD_LSHIFT])
		else $error("left shift still held after release");

endmodule

[hw/rtl/hkc_encode.sv]
// Result formation: shift state, modifier mask and the QWERTY code point lookup.
module hkc_encode
	import hkc_pkg::*;
(
	input  hkc_view_t view,
	output res_item_t res
);

	logic       shift;
	logic [7:0] ch;
	logic       in_rom;

	always_comb begin
		shift  = (|view.mods[MOD_RSHIFT:MOD_LSHIFT]) || view.caps;
		in_rom = (view.key[31:16] == KBD_PAGE) && (view.key[15:0] < ROM_SIZE);
		ch     = shift ? rom_shift(view.key[6:0]) : rom_plain(view.key[6:0]);

		res.accepted       = view.accepted;
		res.modifier_mask  = {view.mods, view.caps};
		res.shift_active   = shift;
		res.last_key_usage = view.key;
		// Meaning wins; otherwise look the key up on the keyboard page
		if (view.cp_valid)
			res.code_point = view.cp;
		else if (in_rom)
			res.code_point = {13'd0, ch};
		else
			res.code_point = '0;
	end

endmodule

[hw/rtl/hid_key_to_codepoint.sv]
// A transaction accepted into the event register moves on through the result register to res.
// Throughput: one event per cycle; the event register advances whenever the
// result register is empty or being taken, so the only stall is a held result.
// Reset clears caps lock, the held modifiers and the stored event to zero and
// empties both the event and the result registers.
module hid_key_to_codepoint
	import hkc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      evt_valid,
	output logic      evt_ready,
	input  evt_item_t evt,
	output logic      res_valid,
	input  logic      res_ready,
	output res_item_t res
);

	logic      vld_s1;
	evt_item_t evt_s1;
	logic      res_valid_q;
	res_item_t res_q;
	logic      advance;
	hkc_view_t view;
	res_item_t res_d;

	// Move the held event on when the result register can take it
	assign advance   = vld_s1 && (!res_valid_q || res_ready);
	assign evt_ready = !vld_s1 || advance;

	// Event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (evt_ready) begin
			vld_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_ready && evt_valid) begin
			evt_s1 <= evt;
		end
	end

	hkc_tracker u_tracker (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.evt     (evt_s1),
		.view    (view)
	);

	hkc_encode u_encode (
		.view (view),
		.res  (res_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// A result only appears from an event that was held in the event register
	a_res_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(vld_s1))
		else $error("result without a held event");

	// Hold a waiting result and its payload until it is taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_ready |=> res_valid_q && $stable(res_q))
		else $error("waiting result dropped or changed");

	// An empty event register always takes a new transaction
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> evt_ready)
		else $error("input stalled with an empty event register");

endmodule

[tb/hkc_checker.sv]
// Checker for the key-to-code-point block: tracks key state and compares every result.
module hkc_checker
	import hkc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      evt_valid,
	input  logic      evt_ready,
	input  evt_item_t evt,
	input  logic      res_valid,
	input  logic      res_ready,
	input  res_item_t res,
	output int        mismatches,
	output int        outstanding,
	output int        checked,
	output int        taken
);
	timeunit 1ns;
	timeprecision 1ps;

	// Tracker state as the block should hold it
	logic        caps_on       = 1'b0;
	logic [5:0]  held_mods     = '0;
	logic        key_stored_ok = 1'b0;
	logic [31:0] key_stored    = '0;
	logic        cp_stored_ok  = 1'b0;
	logic [20:0] cp_stored     = '0;

	// QWERTY glyphs, indexed by usage id on the keyboard page
	logic [7:0] plain_glyph [100];
	logic [7:0] shift_glyph [100];

	res_item_t expected_results [$];
	int        n_bad;
	int        n_checked;
	int        n_taken;

	function automatic void load_glyphs(input int base, input string s, input bit shifted);
		for (int i = 0; i < s.len(); i++) begin
			if (shifted)
				shift_glyph[base + i] = s[i];
			else
				plain_glyph[base + i] = s[i];
		end
	endfunction

	initial begin
		for (int i = 0; i < 100; i++) begin
			plain_glyph[i] = 8'h00;
			shift_glyph[i] = 8'h00;
		end
		load_glyphs(4, "abcdefghijklmnopqrstuvwxyz1234567890", 1'b0);
		load_glyphs(44, " -=[]\\", 1'b0);
		load_glyphs(51, ";'`,./", 1'b0);
		load_glyphs(84, "/*-+", 1'b0);
		load_glyphs(89, "1234567890.", 1'b0);
		load_glyphs(4, "ABCDEFGHIJKLMNOPQRSTUVWXYZ!@#$%^&*()", 1'b1);
		load_glyphs(44, " _+{}|", 1'b1);
		load_glyphs(51, ":\"~<>?", 1'b1);
	end

	// Apply one key event to the tracked state and return the result it should give
	function automatic res_item_t track_key_event(input evt_item_t e);
		res_item_t   r;
		logic        take;
		logic        shifted;
		logic [5:0]  mod_sel;
		logic [31:0] key;
		logic [15:0] id;
		take = e.kind_valid && (e.has_key || e.has_meaning);
		if (take) begin
			key_stored_ok = e.has_key;
			key_stored    = e.has_key ? e.key_usage : '0;
			cp_stored_ok  = e.has_meaning && e.meaning_is_codepoint;
			cp_stored     = cp_stored_ok ? e.meaning_codepoint : '0;
			if (e.has_key) begin
				mod_sel = '0;
				case (e.key_usage)
					KEY_LEFT_SHIFT:  mod_sel[MOD_LSHIFT] = 1'b1;
					KEY_RIGHT_SHIFT: mod_sel[MOD_RSHIFT] = 1'b1;
					KEY_LEFT_CTRL:   mod_sel[MOD_LCTRL]  = 1'b1;
					KEY_RIGHT_CTRL:  mod_sel[MOD_RCTRL]  = 1'b1;
					KEY_LEFT_ALT:    mod_sel[MOD_LALT]   = 1'b1;
					KEY_RIGHT_ALT:   mod_sel[MOD_RALT]   = 1'b1;
					default:         mod_sel = '0;
				endcase
				case (e.kind)
					EVT_SYNC: begin
						held_mods |= mod_sel;
						if (e.key_usage == KEY_CAPS_LOCK)
							caps_on = 1'b1;
					end
					EVT_PRESS: begin
						held_mods |= mod_sel;
						if (e.key_usage == KEY_CAPS_LOCK)
							caps_on = ~caps_on;
					end
					EVT_RELEASE: held_mods &= ~mod_sel;
					default: ;
				endcase
			end
		end

		// Derive the outputs from the state after the update
		shifted = held_mods[MOD_LSHIFT] | held_mods[MOD_RSHIFT] | caps_on;
		key     = key_stored_ok ? key_stored : '0;
		id      = key[15:0];
		r.accepted       = take;
		r.modifier_mask  = {held_mods, caps_on};
		r.shift_active   = shifted;
		r.last_key_usage = key;
		if (cp_stored_ok)
			r.code_point = cp_stored;
		else if (key[31:16] == KBD_PAGE && id < ROM_SIZE)
			r.code_point = {13'd0, shifted ? shift_glyph[id] : plain_glyph[id]};
		else
			r.code_point = '0;
		return r;
	endfunction

	// Compare the result transaction first, then predict for the event transaction
	always @(posedge clk) begin
		res_item_t want;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no expectation waiting: %p", res);
					n_bad++;
				end else begin
					want = expected_results.pop_front();
					n_checked++;
					if (res.accepted !== want.accepted) begin
						$error("accepted: expected %0d, got %0d", want.accepted, res.accepted);
						n_bad++;
					end
					if (res.code_point !== want.code_point) begin
						$error("code_point: expected 0x%0h, got 0x%0h",
							want.code_point, res.code_point);
						n_bad++;
					end
					if (res.modifier_mask !== want.modifier_mask) begin
						$error("modifier_mask: expected 0x%0h, got 0x%0h",
							want.modifier_mask, res.modifier_mask);
						n_bad++;
					end
					if (res.shift_active !== want.shift_active) begin
						$error("shift_active: expected %0d, got %0d",
							want.shift_active, res.shift_active);
						n_bad++;
					end
					if (res.last_key_usage !== want.last_key_usage) begin
						$error("last_key_usage: expected 0x%08h, got 0x%08h",
							want.last_key_usage, res.last_key_usage);
						n_bad++;
					end
				end
			end
			if (evt_valid && evt_ready) begin
				want = track_key_event(evt);
				if (want.accepted)
					n_taken++;
				expected_results.push_back(want);
			end
			mismatches  <= n_bad;
			outstanding <= expected_results.size();
			checked     <= n_checked;
			taken       <= n_taken;
		end
	end

endmodule

[tb/tb.sv]
// Top of the key-to-code-point testbench: clock, reset, event stimulus and verdict.
module tb
	import hkc_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int RANDOM_ITEMS = 1150;
	localparam int HOLD_CYCLES  = 60;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      evt_valid = 1'b0;
	logic      evt_ready;
	evt_item_t evt       = '0;
	logic      res_valid;
	logic      res_ready = 1'b0;
	res_item_t res;

	logic steady = 1'b0;
	int   mismatches;
	int   outstanding;
	int   checked;
	int   taken;
	int   sent;
	int   cycle_count;

	logic [31:0] mod_keys [7] = '{KEY_CAPS_LOCK, KEY_LEFT_CTRL, KEY_LEFT_SHIFT, KEY_LEFT_ALT,
		KEY_RIGHT_CTRL, KEY_RIGHT_SHIFT, KEY_RIGHT_ALT};

	hid_key_to_codepoint uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	hkc_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.evt_valid   (evt_valid),
		.evt_ready   (evt_ready),
		.evt         (evt),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.checked     (checked),
		.taken       (taken)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// End the run if it hangs
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
			outstanding);
		$display("*** FAILED ***");
		$finish;
	end

	// Take results at random, with one long hold-off so the block backs up
	initial begin
		bit held_once;
		held_once = 1'b0;
		forever begin
			@(posedge clk);
			if (!held_once && checked >= 300) begin
				held_once = 1'b1;
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			res_ready <= arst_n && (steady || $urandom_range(99) >= 34);
		end
	end

	function automatic evt_item_t key_event(input logic kind_valid, input logic [1:0] etype,
		input logic has_key, input logic [31:0] usage, input logic has_meaning,
		input logic is_cp, input logic [20:0] cp);
		evt_item_t e;
		e.kind_valid           = kind_valid;
		e.kind                 = etype;
		e.has_key              = has_key;
		e.key_usage            = usage;
		e.has_meaning          = has_meaning;
		e.meaning_is_codepoint = is_cp;
		e.meaning_codepoint    = cp;
		return e;
	endfunction

	// Offer one event transaction, idling first at random; hold it until taken
	task automatic offer_event(input evt_item_t e);
		while (!steady && $urandom_range(99) < 34) begin
			evt_valid <= 1'b0;
			@(posedge clk);
		end
		evt       <= e;
		evt_valid <= 1'b1;
		@(posedge clk);
		while (!evt_ready) @(posedge clk);
		sent++;
	endtask

	// Stop offering until every expected result has come back
	task automatic hold_until_drained();
		evt_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin
		evt_item_t   directed [$];
		evt_item_t   e;
		int          pick;
		logic [31:0] usage;
		sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed events: rejections, ROM columns, keypad, caps lock, every modifier
		directed = '{
			key_event(1'b0, EVT_PRESS,   1'b1, {KBD_PAGE, 16'd4},  1'b1, 1'b1, 21'h41),
			key_event(1'b1, EVT_PRESS,   1'b0, 32'hFFFF_FFFF,      1'b0, 1'b1, 21'h10FFFF),
			key_event(1'b1, EVT_PRESS,   1'b1, {KBD_PAGE, 16'd4},  1'b0, 1'b0, 21'h0),
			key_event(1'b1, EVT_PRESS,   1'b1, KEY_LEFT_SHIFT,     1'b0, 1'b0, 21'h0),
			key_event(1'b1, EVT_PRESS,   1'b1, {KBD_PAGE, 16'd29}, 1'b0, 1'b0, 21'h0),
			key_event(1'b1, EVT_PRESS,   1'b1, {KBD_PAGE, 16'd89}, 1'b0, 1'b0, 21'h0),
			key_event(1'b1, EVT_PRESS,   1'b1, {KBD_PAGE, 16'd56}, 1'b0, 1'b0, 21'h0),
			key_event(1'b1, EVT_RELEASE, 1'b1, KEY_LEFT_SHIFT,     1'b0, 1'b0, 21'h0),
			key_event(1'b1, EVT_PRESS,   1'b1, {KBD_PAGE, 16'd99}, 1'b0, 1'b0, 21'h0),
			key_event(1'b1, EVT_PRESS,   1'b1, KEY_CAPS_LOCK,      1'b0, 1'b0, 21'h0),
			key_event(1'b1, EVT_PRESS,   1'b1, {KBD_PAGE, 16'd20}, 1'b0, 1'b0, 21'h0),
			key_event(1'b1, EVT_PRESS,   1'b1, KEY_CAPS_LOCK,      1'b0, 1'b0, 21'h0),
			key_event(1'b1, EVT_SYNC,    1'b1, KEY_CAPS_LOCK,      1'b0, 1'b0, 21'h0),
			key_event(1'b1, EVT_RELEASE, 1'b1, KEY_CAPS_LOCK,      1'b0, 1'b0, 21'h0),
			key_event(1'b1, EVT_SYNC,    1'b1, KEY_RIGHT_SHIFT,    1'b0, 1'b0, 21'h0),
			key_event(1'b1, EVT_RELEASE, 1'b1, KEY_RIGHT_SHIFT,    1'b0, 1'b0, 21'h0),
			key_event(1'b1, EVT_PRESS,   1'b1, KEY_LEFT_CTRL,      1'b0, 1'b0, 21'h0),
			key_event(1'b1, EVT_PRESS,   1'b1, KEY_RIGHT_CTRL,     1'b0, 1'b0, 21'h0),
			key_event(1'b1, EVT_PRESS,   1'b1, KEY_LEFT_ALT,       1'b0, 1'b0, 21'h0),
			key_event(1'b1, EVT_SYNC,    1'b1, KEY_RIGHT_ALT,      1'b0, 1'b0, 21'h0),
			key_event(1'b1, EVT_CANCEL,  1'b1, KEY_RIGHT_ALT,      1'b0, 1'b0, 21'h0),
			key_event(1'b1, EVT_PRESS,   1'b0, 32'hFFFF_FFFF,      1'b1, 1'b1, 21'h10FFFF),
			key_event(1'b1, EVT_SYNC,    1'b1, {KBD_PAGE, 16'd39}, 1'b1, 1'b0, 21'h0FFFFF),
			key_event(1'b1, EVT_PRESS,   1'b1, {KBD_PAGE, 16'd100}, 1'b0, 1'b0, 21'h0),
			key_event(1'b1, EVT_PRESS,   1'b1, {16'h0008, 16'd4},  1'b0, 1'b0, 21'h0),
			key_event(1'b1, EVT_RELEASE, 1'b1, 32'hFFFF_FFFF,      1'b1, 1'b1, 21'h0)
		};
		foreach (directed[i])
			offer_event(directed[i]);
		hold_until_drained();

		// Random events: mostly well-formed, with key usages biased towards the ROM
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady <= (n >= 600 && n < 800);
			if (n == 900)
				hold_until_drained();
			pick = $urandom_range(99);
			if (pick < 20)
				usage = mod_keys[$urandom_range(6)];
			else if (pick < 75)
				usage = {KBD_PAGE, 16'($urandom_range(99))};
			else if (pick < 85)
				usage = {KBD_PAGE, 16'($urandom)};
			else
				usage = $urandom;
			e = key_event(1'b1, 2'($urandom_range(3)), $urandom_range(99) < 85, usage,
				$urandom_range(99) < 30, 1'($urandom_range(1)),
				21'($urandom_range(1114111)));
			if (!e.has_key)
				e.has_meaning = 1'b1;
			// Mix in events the block must reject
			pick = $urandom_range(99);
			if (pick < 6)
				e.kind_valid = 1'b0;
			else if (pick < 12) begin
				e.has_key     = 1'b0;
				e.has_meaning = 1'b0;
			end
			offer_event(e);
		end
		steady <= 1'b0;

		hold_until_drained();
		repeat (8) @(posedge clk);
		$display("Offered %0d key events, %0d accepted; checked %0d results.", sent, taken,
			checked);
		$display("Covered rejections, all event types, every modifier, caps lock %s",
			"and both ROM columns.");
		if (mismatches == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
